@@ rtl/core/layer_timing_monitor_prefetch_core_assert.svh @@
// Assertion macros for the layer timing monitor prefetch core.
// Define ASSERT_OFF to compile every assertion away.
`ifndef LAYER_TIMING_MONITOR_PREFETCH_CORE_ASSERT_SVH
`define LAYER_TIMING_MONITOR_PREFETCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LTM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LTM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LTM_ASSERT(label, clk, rst_n, prop, msg)
`define LTM_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/ltmp_pkg.sv @@
// Package for the layer timing monitor prefetch core.
// Types, codes and constants shared by controller, datapath and top level.
`timescale 1ns / 1ps
package ltmp_pkg;
	localparam int unsigned MAX_LAYERS_DEF = 256;
	localparam int unsigned TIME_BITS_DEF  = 48;
	localparam int unsigned EMA_W          = 56;
	localparam logic [EMA_W-1:0] ONE_MS_Q8 = 56'd256000000;
	localparam logic [EMA_W-1:0] TEN_MS_Q8 = 56'd2560000000;
	localparam logic [16:0] ALPHA_ONE      = 17'd65536;

	typedef enum logic [2:0] {
		CMD_START    = 3'd0,
		CMD_END      = 3'd1,
		CMD_ABORT    = 3'd2,
		CMD_PREFETCH = 3'd3,
		CMD_QUERY    = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		REG_NUM_LAYERS = 2'd0,
		REG_EMA_ALPHA  = 2'd1,
		REG_EPOCH      = 2'd2
	} reg_e;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_RUNNING  = 2'd1,
		ST_COMPLETE = 2'd2,
		ST_ABORTED  = 2'd3
	} status_e;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_EXEC, S_BLEND, S_WRITE, S_OUT
	} fsm_e;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  layer_index;
		logic [47:0] duration_ns;
		logic [47:0] timestamp_ns;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic        should_prefetch;
		logic        lead_distance;
		logic [1:0]  prefetch_priority;
		logic [32:0] deadline_epoch;
		logic [1:0]  layer_status;
		logic [47:0] ema_out_ns;
		logic [47:0] min_out_ns;
		logic [47:0] max_out_ns;
		logic [63:0] total_out_ns;
		logic [31:0] invalid_count_out;
		logic [31:0] decision_count_out;
	} out_item_t;

	typedef struct packed {
		logic clr_step;
		logic rd;
		logic exec;
		logic blend;
		logic wr;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
	} dp_sts_t;
endpackage

@@ rtl/core/ltmp_ctrl.sv @@
// Controller state machine of the layer timing monitor prefetch core.
// Depends on ltmp_pkg; drives the datapath by dp_cmd_t.
`timescale 1ns / 1ps
module ltmp_ctrl
	import ltmp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	fsm_e state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.rd  = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.exec = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				cmd.blend = 1'b1;
				state_d   = S_BLEND;
			end
			S_BLEND: begin
				cmd.wr  = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ rtl/core/ltmp_dp.sv @@
// Datapath of the layer timing monitor prefetch core: per-layer table memory,
// active-layer tracking, EMA blend and prefetch decision. Depends on ltmp_pkg.
`timescale 1ns / 1ps
`include "layer_timing_monitor_prefetch_core_assert.svh"
module ltmp_dp
	import ltmp_pkg::*;
#(
	parameter int unsigned MAX_LAYERS = MAX_LAYERS_DEF,
	parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  in_item_t    in_item,
	input  logic [8:0]  num_layers,
	input  logic [16:0] ema_alpha,
	input  logic [31:0] epoch,
	output out_item_t   out_item
);
	localparam int unsigned AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int unsigned ENT_W = 3*32 + 64 + 3*48 + EMA_W;
	localparam logic [47:0] TMASK = 48'((64'd1 << TIME_BITS) - 64'd1);

	typedef struct packed {
		logic [31:0] starts;
		logic [31:0] completes;
		logic [31:0] aborts;
		logic [63:0] total;
		logic [47:0] minv;
		logic [47:0] maxv;
		logic [47:0] pad;
		logic [EMA_W-1:0] ema;
	} ent_t;

	logic [ENT_W-1:0] mem [MAX_LAYERS];
	ent_t rd_q, wr_q, nxt_ent, wr_ent;
	in_item_t it_q;
	logic [AW:0] clr_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic mem_we;
	logic [ENT_W-1:0] mem_wd;

	logic        active_valid_q;
	logic [7:0]  active_layer_q;
	logic [47:0] active_start_q;
	logic [31:0] inv_q, dec_q;
	logic        ok_q, in_tab_q, nxt_tab_q;
	logic [47:0] dur_q;
	logic [1:0]  st_q;
	logic [EMA_W-1:0] blend_q;
	logic [63:0] prod_a_q, prod_b_q;
	logic [8:0]  rem_q;
	logic        has_next_q;
	out_item_t   out_q;
	out_item_t   out_c;

	// Clear sweep writes the reset entry; otherwise write the modified one.
	ent_t clr_ent;
	always_comb begin
		clr_ent      = '0;
		clr_ent.minv = TMASK;
	end

	assign sts.clr_done = (clr_q == (AW+1)'(MAX_LAYERS - 1));
	assign mem_we  = cmd.clr_step || (cmd.wr && in_tab_q &&
		(it_q.command == CMD_START || it_q.command == CMD_END || it_q.command == CMD_ABORT)
		&& ok_q);
	assign wr_addr = cmd.clr_step ? clr_q[AW-1:0] : AW'(it_q.layer_index);
	assign mem_wd  = cmd.clr_step ? clr_ent : wr_ent;

	// Prefetch reads the next layer's entry; others read the addressed layer.
	logic [8:0] nxt_idx;
	assign nxt_idx = 9'(in_item.layer_index) + 9'd1;
	assign rd_addr = (in_item.command == CMD_PREFETCH) ? AW'(nxt_idx) : AW'(in_item.layer_index);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= mem_wd;
		if (cmd.rd) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_step && !sts.clr_done) clr_q <= clr_q + 1'b1;
	end

	// Stage A: capture item, evaluate transition, build new entry.
	logic [16:0] a_eff;
	logic [47:0] dur_c;
	assign a_eff = (ema_alpha > ALPHA_ONE) ? ALPHA_ONE : ema_alpha;
	assign dur_c = (it_q.duration_ns != '0) ? (it_q.duration_ns & TMASK)
		: ((it_q.timestamp_ns - active_start_q) & TMASK);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			it_q      <= in_item;
			in_tab_q  <= (32'(in_item.layer_index) < MAX_LAYERS);
			nxt_tab_q <= (32'(nxt_idx) < MAX_LAYERS);
		end
		if (cmd.exec) begin
			dur_q      <= dur_c;
			has_next_q <= (9'(it_q.layer_index) + 9'd1) < num_layers;
			rem_q      <= num_layers - 9'(it_q.layer_index);
			prod_a_q   <= 64'(a_eff) * 64'({dur_c, 8'd0} >> 16);
			prod_b_q   <= 64'(ALPHA_ONE - a_eff) * 64'(rd_q.ema >> 16);
		end
	end

	// Low partial products are narrow; fold them with the high sum.
	logic [EMA_W-1:0] lo_sum;
	logic [15:0] x_lo;
	assign x_lo   = {dur_q[7:0], 8'd0};
	assign lo_sum = EMA_W'(32'(a_eff) * 32'(x_lo))
		+ EMA_W'(32'(ALPHA_ONE - a_eff) * 32'(rd_q.ema[15:0]));

	always_ff @(posedge clk) begin
		if (cmd.blend) blend_q <= EMA_W'(prod_a_q + prod_b_q) + ((lo_sum + 56'd32768) >> 16);
	end

	// Transition check and active tracking at exec.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_valid_q <= 1'b0;
			active_layer_q <= '0;
			active_start_q <= '0;
			inv_q          <= '0;
			dec_q          <= '0;
			ok_q           <= 1'b0;
			st_q           <= ST_IDLE;
		end else if (cmd.exec) begin
			case (it_q.command)
				CMD_START: begin
					if (active_valid_q) begin
						inv_q <= inv_q + 1'b1;
						ok_q  <= 1'b0;
					end else begin
						active_valid_q <= 1'b1;
						active_layer_q <= it_q.layer_index;
						active_start_q <= it_q.timestamp_ns & TMASK;
						ok_q           <= 1'b1;
					end
				end
				CMD_END, CMD_ABORT: begin
					if (!active_valid_q || active_layer_q != it_q.layer_index) begin
						inv_q <= inv_q + 1'b1;
						ok_q  <= 1'b0;
					end else begin
						active_valid_q <= 1'b0;
						active_layer_q <= '0;
						active_start_q <= '0;
						ok_q           <= 1'b1;
					end
				end
				CMD_PREFETCH: begin
					dec_q <= dec_q + 1'b1;
					ok_q  <= 1'b1;
				end
				CMD_QUERY: ok_q <= 1'b1;
				default: ok_q <= 1'b0;
			endcase
			if (active_valid_q && active_layer_q == it_q.layer_index) st_q <= ST_RUNNING;
			else if (!in_tab_q) st_q <= ST_IDLE;
			else if (rd_q.aborts != '0 && rd_q.completes == '0) st_q <= ST_ABORTED;
			else if (rd_q.completes != '0) st_q <= ST_COMPLETE;
			else st_q <= ST_IDLE;
		end
	end

	// New entry at blend stage; the blended EMA joins it on the write.
	always_comb begin
		nxt_ent = rd_q;
		case (it_q.command)
			CMD_START: nxt_ent.starts = rd_q.starts + 1'b1;
			CMD_ABORT: nxt_ent.aborts = rd_q.aborts + 1'b1;
			CMD_END: begin
				nxt_ent.completes = rd_q.completes + 1'b1;
				nxt_ent.total     = rd_q.total + 64'(dur_q);
				if (dur_q < rd_q.minv) nxt_ent.minv = dur_q;
				if (dur_q > rd_q.maxv) nxt_ent.maxv = dur_q;
				if (rd_q.ema == '0) nxt_ent.ema = EMA_W'({dur_q, 8'd0});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.blend) wr_q <= nxt_ent;
	end

	always_comb begin
		wr_ent = wr_q;
		if (it_q.command == CMD_END && rd_q.ema != '0) wr_ent.ema = blend_q;
	end

	// Prefetch decision and result assembly at write stage.
	logic [EMA_W-1:0] nema;
	logic [EMA_W+8:0] ema_rem;
	logic pf;
	logic [1:0] prio;
	assign nema    = nxt_tab_q ? rd_q.ema : '0;
	assign ema_rem = (EMA_W+9)'(nema) * (EMA_W+9)'(rem_q);
	always_comb begin
		pf   = 1'b0;
		prio = 2'd0;
		if (has_next_q) begin
			if (nema == '0) pf = 1'b1;
			else if (!(nema < ONE_MS_Q8 && ema_rem < (EMA_W+9)'(ONE_MS_Q8))) begin
				pf = 1'b1;
				prio = (nema > TEN_MS_Q8) ? 2'd2 : ((nema > ONE_MS_Q8) ? 2'd1 : 2'd0);
			end
		end
	end

	always_comb begin
		out_c                    = '0;
		out_c.accepted           = ok_q;
		out_c.invalid_count_out  = inv_q;
		out_c.decision_count_out = dec_q;
		if (it_q.command == CMD_PREFETCH && pf) begin
			out_c.should_prefetch   = 1'b1;
			out_c.lead_distance     = 1'b1;
			out_c.prefetch_priority = prio;
			out_c.deadline_epoch    = 33'(epoch) + 33'd1;
		end
		if (it_q.command == CMD_QUERY) begin
			out_c.layer_status = st_q;
			if (in_tab_q) begin
				out_c.ema_out_ns   = 48'(rd_q.ema >> 8);
				out_c.min_out_ns   = (rd_q.minv == TMASK) ? '0 : rd_q.minv;
				out_c.max_out_ns   = rd_q.maxv;
				out_c.total_out_ns = rd_q.total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) out_q <= out_c;
		if (cmd.out_load) out_item <= out_q;
	end

	`LTM_ASSERT_NEVER(a_clr_and_wr, clk, arst_n, cmd.clr_step && cmd.wr,
		"table write during clear sweep")
	`LTM_ASSERT(a_inv_step, clk, arst_n,
		cmd.exec |=> (inv_q == $past(inv_q) || inv_q == $past(inv_q) + 32'd1),
		"invalid count jumped")
	`LTM_ASSERT_NEVER(a_clr_and_rd, clk, arst_n, cmd.clr_step && cmd.rd,
		"item read during clear sweep")
	`LTM_ASSERT(a_dec_only_pf, clk, arst_n,
		(cmd.exec && it_q.command != CMD_PREFETCH) |=> dec_q == $past(dec_q),
		"decision count moved on other command")
endmodule

@@ rtl/core/layer_timing_monitor_prefetch_core.sv @@
// Layer timing monitor with prefetch advice.
// Command channel in (in_valid/in_ready, in_item_t), one result per command
// out (out_valid/out_ready, out_item_t), and a plain configuration write port
// (cfg_we, cfg_index, cfg_wdata) for num_layers, ema_alpha and epoch.
// Each command reads the per-layer table memory, and an accepted start, end
// or abort on a layer in the table writes it back: the item is taken, read,
// checked, blended and written back, and its result is then registered in
// the output register. One command is in flight at a time, so a new transfer
// is taken only after the last result has left the write stage.
// After reset the table is swept back to its reset values, one layer a
// cycle, while in_ready stays low; configuration writes are taken
// throughout. Registers reset to num_layers 0, ema_alpha 6554, epoch 0.
// If the receiver stalls, the finished result holds in the output register
// and the next command waits in the write stage until it is taken.
// Layers at or beyond MAX_LAYERS still track as active, but have no entry.
`timescale 1ns / 1ps
module layer_timing_monitor_prefetch_core
	import ltmp_pkg::*;
#(
	parameter int unsigned MAX_LAYERS = MAX_LAYERS_DEF,
	parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	logic [8:0]  num_layers_q;
	logic [16:0] ema_alpha_q;
	logic [31:0] epoch_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	// Configuration registers; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_layers_q <= '0;
			ema_alpha_q  <= 17'd6554;
			epoch_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_LAYERS: num_layers_q <= cfg_wdata[8:0];
				REG_EMA_ALPHA:  ema_alpha_q  <= cfg_wdata[16:0];
				REG_EPOCH:      epoch_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ltmp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	ltmp_dp #(.MAX_LAYERS(MAX_LAYERS), .TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_item(in_item), .num_layers(num_layers_q), .ema_alpha(ema_alpha_q),
		.epoch(epoch_q), .out_item(out_item)
	);
endmodule
